>>> rtl/core/ps2sc_pkg.sv
// Shared types, scancode constants and keymap tables for the PS/2 scancode decoder.
// No dependencies; used by ps2sc_decode, ps2sc_fifo and ps2_scancode_decoder_fifo.
`default_nettype none

package ps2sc_pkg;

    // Character FIFO geometry (holds FIFO_DEPTH-1 characters)
    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    // Request command codes
    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Set 1 scancodes
    localparam logic [7:0] SC_PREFIX = 8'hE0;
    localparam logic [7:0] SC_LSHIFT = 8'h2A;
    localparam logic [7:0] SC_RSHIFT = 8'h36;
    localparam logic [7:0] SC_LCTRL  = 8'h1D;
    localparam logic [7:0] SC_LALT   = 8'h38;
    localparam logic [7:0] SC_CAPS   = 8'h3A;
    localparam logic [7:0] SC_UP     = 8'h48;
    localparam logic [7:0] SC_DOWN   = 8'h50;
    localparam logic [7:0] SC_LEFT   = 8'h4B;
    localparam logic [7:0] SC_RIGHT  = 8'h4D;
    localparam logic [7:0] SC_F1     = 8'h3B;
    localparam logic [7:0] SC_F4     = 8'h3E;
    localparam logic [6:0] SC_CODE_MASK = 7'h7F;

    // Character codes
    localparam logic [7:0] CH_NONE     = 8'h00;
    localparam logic [7:0] CH_UP       = 8'h80;
    localparam logic [7:0] CH_DOWN     = 8'h81;
    localparam logic [7:0] CH_LEFT     = 8'h82;
    localparam logic [7:0] CH_RIGHT    = 8'h83;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CTRL_OFFSET = 8'h60;
    localparam logic [7:0] CASE_FLIP   = 8'd32;

    // Keymap tables, indexed by make code below MAP_SIZE
    localparam logic [7:0] MAP_SIZE  = 8'd58;
    localparam int         MAP_IDX_W = 6;

    localparam logic [7:0] MAP_PLAIN [58] = '{
        8'h00, 8'h1B, "1", "2", "3", "4", "5", "6", "7", "8",
        "9", "0", "-", "=", 8'h08, 8'h09,
        "q", "w", "e", "r", "t", "y", "u", "i", "o", "p",
        "[", "]", 8'h0A, 8'h00,
        "a", "s", "d", "f", "g", "h", "j", "k", "l",
        ";", 8'h27, 8'h60, 8'h00, 8'h5C,
        "z", "x", "c", "v", "b", "n", "m",
        ",", ".", "/", 8'h00,
        "*", 8'h00, " "
    };

    localparam logic [7:0] MAP_SHIFT [58] = '{
        8'h00, 8'h1B, "!", "@", "#", "$", "%", "^", "&", "*",
        "(", ")", "_", "+", 8'h08, 8'h09,
        "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P",
        "{", "}", 8'h0A, 8'h00,
        "A", "S", "D", "F", "G", "H", "J", "K", "L",
        ":", 8'h22, "~", 8'h00, "|",
        "Z", "X", "C", "V", "B", "N", "M",
        "<", ">", "?", 8'h00,
        "*", 8'h00, " "
    };

    // Look up a make code; codes past the table give no character
    function automatic logic [7:0] map_lookup(input logic [7:0] sc, input logic shifted);
        logic [MAP_IDX_W-1:0] idx;
        idx = sc[MAP_IDX_W-1:0];
        if (sc >= MAP_SIZE) begin
            return CH_NONE;
        end
        return shifted ? MAP_SHIFT[idx] : MAP_PLAIN[idx];
    endfunction

    // Modifier and prefix state of the decoder
    typedef struct packed {
        logic shift_held;
        logic caps_on;
        logic ctrl_held;
        logic ext_pending;
    } t_key_flags;

    // Request from the top level to the FIFO, already gated by acceptance
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } t_fifo_req;

    // Per-request FIFO status, valid in the cycle of the request
    typedef struct packed {
        logic popped;
        logic dropped;
        logic key_avail;
    } t_fifo_rsp;

endpackage

`default_nettype wire

>>> rtl/core/ps2_scancode_decoder_fifo.sv
// Top level of the PS/2 Set 1 scancode decoder with character FIFO.
// Depends on ps2sc_pkg, ps2sc_decode and ps2sc_fifo.
//
// Usage:
//   Input channel (i_valid / o_stall): each request is either a scancode byte
//   (i_command = 0, byte on i_scan_byte) or a read (i_command = 1).
//   Output channel (o_valid / i_stall): exactly one result per request, in
//   order: o_read_char / o_read_valid for a pop, o_key_available (FIFO not
//   empty after the request) and o_char_dropped (decoded character lost to a
//   full FIFO). The FIFO holds FIFO_DEPTH-1 characters.
//   Throughput: one request per cycle while o_stall is low. An accepted
//   request passes through the read stage, while the character memory read
//   completes, and then the output register before it shows on o_valid.
//   Stall: a stage behind the memory read and the output register hold up to
//   two results; o_stall rises only when both are full and i_stall is high.
//   Reset: synchronous, active low; empties the FIFO and clears the shift,
//   ctrl, caps-lock and prefix state. No clearing pass; the first request can
//   follow reset directly.
`default_nettype none

module ps2_scancode_decoder_fifo (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_command,
    input  wire logic [7:0] i_scan_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic      [7:0] o_read_char,
    output logic            o_read_valid,
    output logic            o_key_available,
    output logic            o_char_dropped
);

    logic                 accept;
    logic                 scan_en;
    logic [7:0]           dec_char;
    logic [7:0]           rd_data;
    logic                 s1_adv;
    ps2sc_pkg::t_fifo_req fifo_req;
    ps2sc_pkg::t_fifo_rsp fifo_rsp;

    logic                 r_s1_valid;
    ps2sc_pkg::t_fifo_rsp r_s1_rsp;
    logic                 r_out_valid;
    logic [7:0]           r_out_char;
    ps2sc_pkg::t_fifo_rsp r_out_rsp;

    // Handshake: take a request when the read stage is empty or moving on
    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign accept  = i_valid && !o_stall;
    assign scan_en = accept && (i_command == ps2sc_pkg::CMD_SCAN);

    ps2sc_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (scan_en),
        .i_scan_byte (i_scan_byte),
        .o_char      (dec_char)
    );

    // Push nonzero characters; pop on read requests
    always_comb begin
        fifo_req.push = scan_en && (dec_char != ps2sc_pkg::CH_NONE);
        fifo_req.pop  = accept && (i_command == ps2sc_pkg::CMD_READ);
        fifo_req.data = dec_char;
    end

    ps2sc_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (fifo_req),
        .o_rsp     (fifo_rsp),
        .o_rd_data (rd_data)
    );

    // Read stage: hold status while the memory data arrives
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rsp <= fifo_rsp;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_char <= r_s1_rsp.popped ? rd_data : ps2sc_pkg::CH_NONE;
            r_out_rsp  <= r_s1_rsp;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_read_char     = r_out_char;
    assign o_read_valid    = r_out_rsp.popped;
    assign o_key_available = r_out_rsp.key_avail;
    assign o_char_dropped  = r_out_rsp.dropped;

    // A popped character was pushed as nonzero
    a_pop_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_read_valid) |-> (o_read_char != ps2sc_pkg::CH_NONE))
        else $error("popped character is zero");

    // No character is reported without a pop
    a_no_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_read_valid) |-> (o_read_char == ps2sc_pkg::CH_NONE))
        else $error("character reported without a pop");

    // A pop never drops a character
    a_pop_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_read_valid) |-> !o_char_dropped)
        else $error("drop reported on a read");

    // A drop means the FIFO was full, so it cannot be empty afterwards
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_dropped) |-> o_key_available)
        else $error("drop reported with an empty FIFO");

endmodule

`default_nettype wire

>>> rtl/core/ps2sc_decode.sv
// Scancode decoder: modifier/prefix flags and translation of one byte to a character.
// Depends on ps2sc_pkg for scancodes, keymap tables and t_key_flags.
`default_nettype none

module ps2sc_decode (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_scan_byte,
    output logic      [7:0] o_char
);

    ps2sc_pkg::t_key_flags r_flags;
    ps2sc_pkg::t_key_flags n_flags;
    logic [7:0]            rel_code;
    logic [7:0]            plain_ch;
    logic [7:0]            map_ch;

    assign rel_code = {1'b0, i_scan_byte[6:0] & ps2sc_pkg::SC_CODE_MASK};
    assign plain_ch = ps2sc_pkg::map_lookup(i_scan_byte, 1'b0);
    assign map_ch   = ps2sc_pkg::map_lookup(i_scan_byte, r_flags.shift_held);

    // Decode the byte against the current flags
    always_comb begin
        n_flags = r_flags;
        o_char  = ps2sc_pkg::CH_NONE;
        priority if (i_scan_byte == ps2sc_pkg::SC_PREFIX) begin
            n_flags.ext_pending = 1'b1;
        end else if (r_flags.ext_pending) begin
            n_flags.ext_pending = 1'b0;
            if (!i_scan_byte[7]) begin
                priority if (i_scan_byte == ps2sc_pkg::SC_UP) begin
                    o_char = ps2sc_pkg::CH_UP;
                end else if (i_scan_byte == ps2sc_pkg::SC_DOWN) begin
                    o_char = ps2sc_pkg::CH_DOWN;
                end else if (i_scan_byte == ps2sc_pkg::SC_LEFT) begin
                    o_char = ps2sc_pkg::CH_LEFT;
                end else if (i_scan_byte == ps2sc_pkg::SC_RIGHT) begin
                    o_char = ps2sc_pkg::CH_RIGHT;
                end else begin
                    o_char = ps2sc_pkg::CH_NONE;
                end
            end
        end else if (i_scan_byte[7]) begin
            // Release: only shift and ctrl matter
            if (rel_code == ps2sc_pkg::SC_LSHIFT || rel_code == ps2sc_pkg::SC_RSHIFT) begin
                n_flags.shift_held = 1'b0;
            end
            if (rel_code == ps2sc_pkg::SC_LCTRL) begin
                n_flags.ctrl_held = 1'b0;
            end
        end else if (i_scan_byte == ps2sc_pkg::SC_LSHIFT
                     || i_scan_byte == ps2sc_pkg::SC_RSHIFT) begin
            n_flags.shift_held = 1'b1;
        end else if (i_scan_byte == ps2sc_pkg::SC_CAPS) begin
            n_flags.caps_on = !r_flags.caps_on;
        end else if (i_scan_byte == ps2sc_pkg::SC_LCTRL) begin
            n_flags.ctrl_held = 1'b1;
        end else if (i_scan_byte == ps2sc_pkg::SC_LALT) begin
            o_char = ps2sc_pkg::CH_NONE;
        end else if (r_flags.ctrl_held && plain_ch >= ps2sc_pkg::CH_LOWER_A
                     && plain_ch <= ps2sc_pkg::CH_LOWER_Z) begin
            // Ctrl plus letter gives control codes 1 to 26
            o_char = plain_ch - ps2sc_pkg::CTRL_OFFSET;
        end else if (i_scan_byte >= ps2sc_pkg::SC_F1 && i_scan_byte <= ps2sc_pkg::SC_F4) begin
            o_char = i_scan_byte;
        end else if (r_flags.caps_on && !r_flags.shift_held
                     && map_ch >= ps2sc_pkg::CH_LOWER_A && map_ch <= ps2sc_pkg::CH_LOWER_Z) begin
            o_char = map_ch - ps2sc_pkg::CASE_FLIP;
        end else if (r_flags.caps_on && r_flags.shift_held
                     && map_ch >= ps2sc_pkg::CH_UPPER_A && map_ch <= ps2sc_pkg::CH_UPPER_Z) begin
            o_char = map_ch + ps2sc_pkg::CASE_FLIP;
        end else begin
            o_char = map_ch;
        end
    end

    // Advance the flags on every accepted scancode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_en) begin
            r_flags <= n_flags;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ps2sc_fifo.sv
// Circular character FIFO in a synchronous memory with a registered read.
// Depends on ps2sc_pkg for depth, pointer width and request/status structs.
`default_nettype none

module ps2sc_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ps2sc_pkg::t_fifo_req  i_req,
    output ps2sc_pkg::t_fifo_rsp       o_rsp,
    output logic                 [7:0] o_rd_data
);

    localparam int PW = ps2sc_pkg::PTR_W;

    logic [7:0]    r_mem [ps2sc_pkg::FIFO_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW-1:0] n_wp;
    logic [PW-1:0] n_rp;
    logic [PW-1:0] wp_inc;
    logic [PW-1:0] rp_inc;
    logic          full;
    logic          empty;
    logic          push_en;
    logic          pop_en;

    // Wrap pointers at the depth, which need not be a power of two
    assign wp_inc = (r_wp == PW'(ps2sc_pkg::FIFO_DEPTH - 1)) ? '0 : r_wp + PW'(1);
    assign rp_inc = (r_rp == PW'(ps2sc_pkg::FIFO_DEPTH - 1)) ? '0 : r_rp + PW'(1);
    assign full   = (wp_inc == r_rp);
    assign empty  = (r_wp == r_rp);

    assign push_en = i_req.push && !full;
    assign pop_en  = i_req.pop && !empty;
    assign n_wp    = push_en ? wp_inc : r_wp;
    assign n_rp    = pop_en ? rp_inc : r_rp;

    assign o_rsp.popped    = pop_en;
    assign o_rsp.dropped   = i_req.push && full;
    assign o_rsp.key_avail = (n_wp != n_rp);

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    // Write pushed characters; read the head on a pop and hold it otherwise
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wp] <= i_req.data;
        end
        if (pop_en) begin
            o_rd_data <= r_mem[r_rp];
        end
    end

endmodule

`default_nettype wire

>>> tb/ps2_scancode_decoder_fifo_tb.sv
// Self-checking testbench for ps2_scancode_decoder_fifo: scancode decode and character FIFO.
// Depends on ps2sc_pkg for command codes, scancodes, character codes and FIFO_DEPTH.
// Directed rows, a FIFO fill and drain, then random key sequences under three idle profiles.
`timescale 1ns / 100ps

module ps2_scancode_decoder_fifo_tb;

    localparam int  CYCLE_LIMIT      = 500000;
    localparam int  RANDOM_PER_PHASE = 355;
    localparam int  HOLD_CYCLES      = 600;
    localparam int  DRAIN_CYCLES     = 8;
    localparam int  KEYMAP_LEN       = 58;
    localparam logic [7:0] RELEASE_BIT = 8'h80;

    typedef struct packed {
        logic [7:0] ch;
        logic       rvalid;
        logic       avail;
        logic       dropped;
    } t_key_result;

    typedef struct packed {
        logic        cmd;
        logic  [7:0] sc;
        logic        typed;
        t_key_result res;
    } t_stim_row;

    // Results that can be read off at a glance
    localparam t_key_result RES_IDLE    = '{ps2sc_pkg::CH_NONE, 1'b0, 1'b0, 1'b0};
    localparam t_key_result RES_QUEUED  = '{ps2sc_pkg::CH_NONE, 1'b0, 1'b1, 1'b0};
    localparam t_key_result RES_POP_A   = '{ps2sc_pkg::CH_LOWER_A, 1'b1, 1'b0, 1'b0};
    localparam t_key_result RES_DROPPED = '{ps2sc_pkg::CH_NONE, 1'b0, 1'b1, 1'b1};

    // US keymaps for make codes below KEYMAP_LEN
    localparam logic [7:0] KEYS_PLAIN [KEYMAP_LEN] = '{
        8'h00, 8'h1B, "1", "2", "3", "4", "5", "6", "7", "8",
        "9", "0", "-", "=", 8'h08, 8'h09,
        "q", "w", "e", "r", "t", "y", "u", "i", "o", "p",
        "[", "]", 8'h0A, 8'h00,
        "a", "s", "d", "f", "g", "h", "j", "k", "l",
        ";", 8'h27, 8'h60, 8'h00, 8'h5C,
        "z", "x", "c", "v", "b", "n", "m",
        ",", ".", "/", 8'h00,
        "*", 8'h00, " "
    };

    localparam logic [7:0] KEYS_SHIFTED [KEYMAP_LEN] = '{
        8'h00, 8'h1B, "!", "@", "#", "$", "%", "^", "&", "*",
        "(", ")", "_", "+", 8'h08, 8'h09,
        "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P",
        "{", "}", 8'h0A, 8'h00,
        "A", "S", "D", "F", "G", "H", "J", "K", "L",
        ":", 8'h22, "~", 8'h00, "|",
        "Z", "X", "C", "V", "B", "N", "M",
        "<", ">", "?", 8'h00,
        "*", 8'h00, " "
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic       i_command;
    logic [7:0] i_scan_byte;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_read_char;
    logic       o_read_valid;
    logic       o_key_available;
    logic       o_char_dropped;

    // Predictor state
    logic [7:0]  queued_chars [$];
    bit          shift_q, caps_q, ctrl_q, ext_q;
    t_key_result pending_results [$];
    t_key_result next_want;
    t_stim_row   directed_rows [$];

    int error_count   = 0;
    int cycle_count   = 0;
    int requests_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int read_pct      = 30;
    bit hold_go       = 1'b0;
    logic hold_off    = 1'b0;

    ps2_scancode_decoder_fifo dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_scan_byte     (i_scan_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_read_char     (o_read_char),
        .o_read_valid    (o_read_valid),
        .o_key_available (o_key_available),
        .o_char_dropped  (o_char_dropped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decode one scancode byte and update the modifier and prefix flags
    function automatic logic [7:0] decode_scancode(input logic [7:0] sc);
        logic [7:0] ch;
        logic [6:0] rel;
        ch  = ps2sc_pkg::CH_NONE;
        rel = sc[6:0];
        if (sc == ps2sc_pkg::SC_PREFIX) begin
            ext_q = 1'b1;
            return ps2sc_pkg::CH_NONE;
        end
        if (ext_q) begin
            ext_q = 1'b0;
            if (sc[7]) return ps2sc_pkg::CH_NONE;
            case (sc)
                ps2sc_pkg::SC_UP:    return ps2sc_pkg::CH_UP;
                ps2sc_pkg::SC_DOWN:  return ps2sc_pkg::CH_DOWN;
                ps2sc_pkg::SC_LEFT:  return ps2sc_pkg::CH_LEFT;
                ps2sc_pkg::SC_RIGHT: return ps2sc_pkg::CH_RIGHT;
                default:             return ps2sc_pkg::CH_NONE;
            endcase
        end
        // Release codes only matter for shift and ctrl
        if (sc[7]) begin
            if (rel == ps2sc_pkg::SC_LSHIFT[6:0] || rel == ps2sc_pkg::SC_RSHIFT[6:0])
                shift_q = 1'b0;
            if (rel == ps2sc_pkg::SC_LCTRL[6:0]) ctrl_q = 1'b0;
            return ps2sc_pkg::CH_NONE;
        end
        if (sc == ps2sc_pkg::SC_LSHIFT || sc == ps2sc_pkg::SC_RSHIFT) begin
            shift_q = 1'b1;
            return ps2sc_pkg::CH_NONE;
        end
        if (sc == ps2sc_pkg::SC_CAPS) begin
            caps_q = !caps_q;
            return ps2sc_pkg::CH_NONE;
        end
        if (sc == ps2sc_pkg::SC_LCTRL) begin
            ctrl_q = 1'b1;
            return ps2sc_pkg::CH_NONE;
        end
        if (sc == ps2sc_pkg::SC_LALT) return ps2sc_pkg::CH_NONE;
        // Ctrl plus a letter gives a control code; other keys fall through
        if (ctrl_q && sc < KEYMAP_LEN) begin
            ch = KEYS_PLAIN[sc[5:0]];
            if (ch >= ps2sc_pkg::CH_LOWER_A && ch <= ps2sc_pkg::CH_LOWER_Z)
                return ch - ps2sc_pkg::CTRL_OFFSET;
        end
        if (sc >= ps2sc_pkg::SC_F1 && sc <= ps2sc_pkg::SC_F4) return sc;
        if (sc >= KEYMAP_LEN) return ps2sc_pkg::CH_NONE;
        ch = shift_q ? KEYS_SHIFTED[sc[5:0]] : KEYS_PLAIN[sc[5:0]];
        if (caps_q && !shift_q && ch >= ps2sc_pkg::CH_LOWER_A && ch <= ps2sc_pkg::CH_LOWER_Z)
            ch = ch - ps2sc_pkg::CASE_FLIP;
        else if (caps_q && shift_q && ch >= ps2sc_pkg::CH_UPPER_A
                 && ch <= ps2sc_pkg::CH_UPPER_Z)
            ch = ch + ps2sc_pkg::CASE_FLIP;
        return ch;
    endfunction

    // Apply one request to the predictor and return the result it causes
    function automatic t_key_result predict_key_result(input logic cmd, input logic [7:0] sc);
        t_key_result res;
        logic [7:0]  ch;
        res = RES_IDLE;
        if (cmd == ps2sc_pkg::CMD_READ) begin
            if (queued_chars.size() != 0) begin
                res.ch     = queued_chars.pop_front();
                res.rvalid = 1'b1;
            end
        end else begin
            ch = decode_scancode(sc);
            if (ch != ps2sc_pkg::CH_NONE) begin
                if (queued_chars.size() == ps2sc_pkg::FIFO_DEPTH - 1) res.dropped = 1'b1;
                else queued_chars.push_back(ch);
            end
        end
        res.avail = (queued_chars.size() != 0);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Offer one request after a random idle gap and hold it until accepted
    task automatic send_request(input logic cmd, input logic [7:0] sc,
                                input logic typed, input t_key_result typed_res);
        int          gap;
        t_key_result res;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_scan_byte <= sc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        res = predict_key_result(cmd, sc);
        pending_results.push_back(typed ? typed_res : res);
        requests_sent++;
    endtask

    function automatic logic [7:0] pick_key();
        if ($urandom_range(9) < 8) return 8'($urandom_range(0, 8'h3F));
        return 8'($urandom_range(0, 8'h7F));
    endfunction

    // Send reads or one random key sequence, sometimes left incomplete
    task automatic send_key_sequence();
        int         kind;
        int         n;
        logic [7:0] key;
        logic [7:0] modk;
        kind = $urandom_range(99);
        key  = pick_key();
        if ($urandom_range(99) < read_pct) begin
            n = $urandom_range(1, 3);
            repeat (n)
                send_request(ps2sc_pkg::CMD_READ, 8'($urandom_range(0, 255)), 1'b0, RES_IDLE);
        end else if (kind < 35) begin
            send_request(ps2sc_pkg::CMD_SCAN, key, 1'b0, RES_IDLE);
            if ($urandom_range(4) != 0)
                send_request(ps2sc_pkg::CMD_SCAN, key | RELEASE_BIT, 1'b0, RES_IDLE);
        end else if (kind < 50) begin
            modk = $urandom_range(1) ? ps2sc_pkg::SC_LSHIFT : ps2sc_pkg::SC_RSHIFT;
            send_request(ps2sc_pkg::CMD_SCAN, modk, 1'b0, RES_IDLE);
            send_request(ps2sc_pkg::CMD_SCAN, key, 1'b0, RES_IDLE);
            send_request(ps2sc_pkg::CMD_SCAN, key | RELEASE_BIT, 1'b0, RES_IDLE);
            if ($urandom_range(9) != 0)
                send_request(ps2sc_pkg::CMD_SCAN, modk | RELEASE_BIT, 1'b0, RES_IDLE);
        end else if (kind < 60) begin
            send_request(ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_LCTRL, 1'b0, RES_IDLE);
            send_request(ps2sc_pkg::CMD_SCAN, key, 1'b0, RES_IDLE);
            send_request(ps2sc_pkg::CMD_SCAN, key | RELEASE_BIT, 1'b0, RES_IDLE);
            if ($urandom_range(9) != 0)
                send_request(ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_LCTRL | RELEASE_BIT,
                             1'b0, RES_IDLE);
        end else if (kind < 66) begin
            send_request(ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_CAPS, 1'b0, RES_IDLE);
            send_request(ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_CAPS | RELEASE_BIT, 1'b0, RES_IDLE);
        end else if (kind < 80) begin
            case ($urandom_range(3))
                0:       modk = ps2sc_pkg::SC_UP;
                1:       modk = ps2sc_pkg::SC_DOWN;
                2:       modk = ps2sc_pkg::SC_LEFT;
                default: modk = ps2sc_pkg::SC_RIGHT;
            endcase
            send_request(ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_PREFIX, 1'b0, RES_IDLE);
            send_request(ps2sc_pkg::CMD_SCAN, modk, 1'b0, RES_IDLE);
            send_request(ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_PREFIX, 1'b0, RES_IDLE);
            send_request(ps2sc_pkg::CMD_SCAN, modk | RELEASE_BIT, 1'b0, RES_IDLE);
        end else if (kind < 88) begin
            send_request(ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_PREFIX, 1'b0, RES_IDLE);
            send_request(ps2sc_pkg::CMD_SCAN, 8'($urandom_range(0, 255)), 1'b0, RES_IDLE);
        end else begin
            send_request(ps2sc_pkg::CMD_SCAN, 8'($urandom_range(0, 255)), 1'b0, RES_IDLE);
        end
    endtask

    // Drive receiver stall from the random profile and the long hold-off
    always @(posedge i_clk) begin
        i_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // Hold off the receiver for a long stretch once requested
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with no request pending, char %h",
                                          o_read_char));
            end else begin
                next_want = pending_results.pop_front();
                if (o_read_char !== next_want.ch)
                    report_mismatch($sformatf("read_char got %h want %h",
                                              o_read_char, next_want.ch));
                if (o_read_valid !== next_want.rvalid)
                    report_mismatch($sformatf("read_valid got %b want %b",
                                              o_read_valid, next_want.rvalid));
                if (o_key_available !== next_want.avail)
                    report_mismatch($sformatf("key_available got %b want %b",
                                              o_key_available, next_want.avail));
                if (o_char_dropped !== next_want.dropped)
                    report_mismatch($sformatf("char_dropped got %b want %b",
                                              o_char_dropped, next_want.dropped));
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int phase_end;
        int next_mix;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_command   = ps2sc_pkg::CMD_SCAN;
        i_scan_byte = 8'h00;
        shift_q = 1'b0;
        caps_q  = 1'b0;
        ctrl_q  = 1'b0;
        ext_q   = 1'b0;

        // Directed table: extremes, modifiers, prefix handling, special keys
        directed_rows.push_back('{ps2sc_pkg::CMD_READ, 8'hFF, 1'b1, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, 8'h00, 1'b1, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, 8'hFF, 1'b1, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, 8'h1E, 1'b1, RES_QUEUED});
        directed_rows.push_back('{ps2sc_pkg::CMD_READ, 8'h00, 1'b1, RES_POP_A});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_F1, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_F4, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, 8'h7F, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_LSHIFT, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, 8'h1E, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, 8'h02, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_CAPS, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, 8'h10, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_LSHIFT | RELEASE_BIT,
                                  1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, 8'h10, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_CAPS, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_LCTRL, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, 8'h2E, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, 8'h02, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_LCTRL | RELEASE_BIT,
                                  1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_PREFIX, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_PREFIX, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_UP, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_PREFIX, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_UP | RELEASE_BIT,
                                  1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, ps2sc_pkg::SC_LALT, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_SCAN, 8'h39, 1'b0, RES_IDLE});
        directed_rows.push_back('{ps2sc_pkg::CMD_READ, 8'hAA, 1'b0, RES_IDLE});

        // Hold reset, then release it once
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 20;
        recv_idle_pct = 84;
        foreach (directed_rows[i])
            send_request(directed_rows[i].cmd, directed_rows[i].sc,
                         directed_rows[i].typed, directed_rows[i].res);

        // Fill the FIFO, push one more into a full FIFO, then drain past empty
        while (queued_chars.size() < ps2sc_pkg::FIFO_DEPTH - 1)
            send_request(ps2sc_pkg::CMD_SCAN, 8'($urandom_range(8'h10, 8'h19)), 1'b0, RES_IDLE);
        send_request(ps2sc_pkg::CMD_SCAN, 8'h1E, 1'b1, RES_DROPPED);
        while (queued_chars.size() != 0)
            send_request(ps2sc_pkg::CMD_READ, 8'($urandom_range(0, 255)), 1'b0, RES_IDLE);
        send_request(ps2sc_pkg::CMD_READ, 8'h00, 1'b1, RES_IDLE);

        // Random key sequences under three idle profiles
        next_mix = requests_sent;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 84;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_go       = 1'b1;
                end
            endcase
            phase_end = requests_sent + RANDOM_PER_PHASE;
            while (requests_sent < phase_end) begin
                if (requests_sent >= next_mix) begin
                    case ($urandom_range(3))
                        0:       read_pct = 0;
                        1:       read_pct = 10;
                        2:       read_pct = 35;
                        default: read_pct = 60;
                    endcase
                    next_mix = requests_sent + 256;
                end
                send_key_sequence();
            end
        end
        i_valid <= 1'b0;

        // Wait for every expected result, then watch for strays
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
